// ----- design/qou_pkg.sv -----
// shared constants, types and helpers for the quaternion orientation update block
// no dependencies
`timescale 1ns / 1ps

package qou_pkg;

    localparam int QW = 18;
    localparam logic signed [QW-1:0] Q_MAX = 18'sd131071;
    localparam logic signed [QW-1:0] Q_MIN = -18'sd131072;
    localparam logic signed [QW-1:0] Q_ONE = 18'sd65536;
    localparam logic [37:0] MAG_MIN_SQ = 38'd43;

    localparam logic CMD_SET    = 1'b0;
    localparam logic CMD_ROTATE = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PROD = 6'b000010,
        ST_SQ   = 6'b000100,
        ST_SQRT = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    // hamilton product: term j of component c uses a[j] * b[j ^ c]
    function automatic logic hp_neg(input logic [1:0] c, input logic [1:0] j);
        logic n;
        begin
            unique case (c)
                2'd0: n = (j != 2'd0);
                2'd1: n = (j == 2'd3);
                2'd2: n = (j == 2'd1);
                default: n = (j == 2'd2);
            endcase
            return n;
        end
    endfunction

    function automatic logic signed [QW-1:0] sat38(input logic signed [37:0] v);
        logic signed [QW-1:0] r;
        begin
            if (v > 38'sd131071)
                r = Q_MAX;
            else if (v < -38'sd131072)
                r = Q_MIN;
            else
                r = v[QW-1:0];
            return r;
        end
    endfunction

endpackage

// ----- design/qou_mul.sv -----
// shared 18x18 signed multiplier with registered product
// depends on qou_pkg
`timescale 1ns / 1ps

module qou_mul
    import qou_pkg::*;
(
    input  logic                  clk,
    input  logic signed [QW-1:0]  a,
    input  logic signed [QW-1:0]  b,
    output logic signed [35:0]    p
);

    logic signed [35:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

// ----- design/qou_isqrt.sv -----
// bit-serial integer square root, one result bit per cycle
// depends on qou_pkg
`timescale 1ns / 1ps

module qou_isqrt
    import qou_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [57:0] radicand,
    output logic        done,
    output logic [28:0] root
);

    logic [57:0] rad_reg;
    logic [33:0] rem_reg;
    logic [28:0] root_reg;
    logic [4:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [33:0] rem_sh;
    logic [33:0] trial;
    logic        ge;

    assign rem_sh = {rem_reg[31:0], rad_reg[57:56]};
    assign trial  = {3'b000, root_reg, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 5'd28;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 5'd1;
                if (step_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[55:0], 2'b00};
            rem_reg  <= ge ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[27:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- design/qou_div.sv -----
// restoring divider, 18 quotient bits, one bit per cycle
// depends on qou_pkg
`timescale 1ns / 1ps

module qou_div
    import qou_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [43:0] num,
    input  logic [28:0] den,
    output logic        done,
    output logic [17:0] quot
);

    logic [43:0] rem_reg;
    logic [45:0] d_reg;
    logic [17:0] q_reg;
    logic [4:0]  step_reg;
    logic        busy_reg;
    logic        done_reg;
    logic        ge;

    assign ge = ({2'b00, rem_reg} >= d_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 5'd17;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 5'd1;
                if (step_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            d_reg   <= {den, 17'b0};
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
                rem_reg <= rem_reg - d_reg[43:0];
            q_reg <= {q_reg[16:0], ge};
            d_reg <= {1'b0, d_reg[45:1]};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ----- design/quaternion_orientation_update.sv -----
// orientation keeper: a rotate request forms the hamilton product with the current orientation,
// then the squared magnitude (set: the squared magnitude only), then a bit-serial square root
// and a division of each component by that root.
// small magnitudes skip both the root and the divisions. ready only while
// idle, so a new request is taken only once the current one is through; a result may wait at the output
// while the next request is taken. reset loads the identity orientation.
`timescale 1ns / 1ps

module quaternion_orientation_update
    import qou_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // rot_w, rot_x, rot_y, rot_z
    input  logic [0:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // ori_w, ori_x, ori_y, ori_z
    output logic [0:0]  m_tuser    // normalized
);

    state_t state_reg;
    logic [4:0] cnt_reg;
    logic signed [QW-1:0] ori_reg [4];
    logic signed [QW-1:0] in_reg [4];
    logic signed [QW-1:0] q_reg [4];
    logic signed [37:0] acc_reg;
    logic p_valid_reg, p_first_reg, p_neg_reg, p_last_reg, p_sq_reg;
    logic [1:0] p_comp_reg;
    logic [28:0] m_reg;
    logic div_run_reg;
    logic norm_reg;
    logic m_tvalid_reg;
    logic [71:0] m_tdata_reg;
    logic m_tuser_reg;

    logic signed [QW-1:0] mul_a, mul_b;
    logic signed [35:0] prod;
    logic issue;
    logic [1:0] i_comp, i_term;
    logic signed [37:0] acc_sum;
    logic signed [37:0] rnd;
    logic sqrt_start, sqrt_done, div_start, div_done;
    logic [28:0] root;
    logic [17:0] quot;
    logic [43:0] num;
    logic [17:0] mag;
    logic c_neg;
    logic signed [QW-1:0] div_res;
    logic accept;

    assign accept = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);

    assign i_comp = cnt_reg[3:2];
    assign i_term = cnt_reg[1:0];
    assign issue = ((state_reg == ST_PROD) && !cnt_reg[4]) ||
                   ((state_reg == ST_SQ) && (cnt_reg < 5'd4));

    always_comb
    begin
        if (state_reg == ST_PROD)
        begin
            mul_a = ori_reg[i_term];
            mul_b = in_reg[i_term ^ i_comp];
        end
        else
        begin
            mul_a = q_reg[i_term];
            mul_b = q_reg[i_term];
        end
    end

    qou_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

    assign acc_sum = (p_first_reg ? 38'sd0 : acc_reg) +
                     (p_neg_reg ? -{{2{prod[35]}}, prod} : {{2{prod[35]}}, prod});
    assign rnd = (acc_sum + 38'sd32768) >>> 16;

    assign sqrt_start = p_valid_reg && p_last_reg && p_sq_reg && (acc_sum >= MAG_MIN_SQ);

    qou_isqrt u_isqrt (
        .clk(clk), .rst_n(rst_n), .start(sqrt_start),
        .radicand({1'b0, acc_sum[36:0], 20'b0}), .done(sqrt_done), .root(root)
    );

    // magnitude of the component being divided, with half-divisor rounding
    assign c_neg = q_reg[cnt_reg[1:0]][QW-1];
    assign mag = c_neg ? (18'd0 - q_reg[cnt_reg[1:0]]) : q_reg[cnt_reg[1:0]];
    assign num = {mag, 26'b0} + {16'b0, m_reg[28:1]};
    assign div_start = (state_reg == ST_DIV) && !div_run_reg;

    qou_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(num), .den(m_reg), .done(div_done), .quot(quot)
    );

    always_comb
    begin
        if (c_neg)
            div_res = (quot >= 18'd131072) ? Q_MIN : -quot;
        else
            div_res = (quot > 18'd131071) ? Q_MAX : quot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            p_valid_reg  <= 1'b0;
            div_run_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            ori_reg[0]   <= Q_ONE;
            ori_reg[1]   <= '0;
            ori_reg[2]   <= '0;
            ori_reg[3]   <= '0;
        end
        else
        begin
            p_valid_reg <= issue;
            if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            if (issue)
                cnt_reg <= cnt_reg + 5'd1;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (s_tuser[0] == CMD_ROTATE) ? ST_PROD : ST_SQ;
                    end
                end
                ST_PROD:
                begin
                    if (p_valid_reg && p_last_reg && (p_comp_reg == 2'd3))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    if (p_valid_reg && p_last_reg)
                        state_reg <= sqrt_start ? ST_SQRT : ST_FIN;
                end
                ST_SQRT:
                begin
                    if (sqrt_done)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_start)
                        div_run_reg <= 1'b1;
                    else if (div_done)
                    begin
                        div_run_reg <= 1'b0;
                        cnt_reg     <= cnt_reg + 5'd1;
                        if (cnt_reg[1:0] == 2'd3)
                            state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        for (int i = 0; i < 4; i++)
                            ori_reg[i] <= q_reg[i];
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        p_first_reg <= (i_term == 2'd0);
        p_last_reg  <= (state_reg == ST_SQ) ? (cnt_reg == 5'd3) : (i_term == 2'd3);
        p_neg_reg   <= (state_reg == ST_PROD) ? hp_neg(i_comp, i_term) : 1'b0;
        p_sq_reg    <= (state_reg == ST_SQ);
        p_comp_reg  <= i_comp;
        if (p_valid_reg)
            acc_reg <= acc_sum;

        if (accept)
        begin
            for (int i = 0; i < 4; i++)
            begin
                in_reg[i] <= s_tdata[i*QW +: QW];
                q_reg[i]  <= s_tdata[i*QW +: QW];
            end
        end
        else if ((state_reg == ST_PROD) && p_valid_reg && p_last_reg)
            q_reg[p_comp_reg] <= sat38(rnd);
        else if ((state_reg == ST_DIV) && div_done)
            q_reg[cnt_reg[1:0]] <= div_res;

        if (sqrt_done)
            m_reg <= root;
        if ((state_reg == ST_SQ) && p_valid_reg && p_last_reg)
            norm_reg <= sqrt_start;

        if ((state_reg == ST_FIN) && (!m_tvalid_reg || m_tready))
        begin
            m_tdata_reg <= {q_reg[3], q_reg[2], q_reg[1], q_reg[0]};
            m_tuser_reg <= norm_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule
